[hw/rtl/frs_pkg.sv]
// ----------------------------------------------------------------------------
// frs_pkg
// Shared constants, codes and controller/datapath interface types for the
// FIRE relaxation step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package frs_pkg;

  localparam int NODES     = 64;
  localparam int ADDR_W    = $clog2(NODES);
  localparam int CNT_W     = $clog2(NODES + 1);
  localparam int IDX_W     = 6;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [23:0] DT_START_RST    = 24'd655;
  localparam logic [23:0] DT_MAX_RST      = 24'd6554;
  localparam logic [15:0] GROW_RST        = 16'd18022;
  localparam logic [15:0] SHRINK_RST      = 16'd8192;
  localparam logic [15:0] ALPHA_START_RST = 16'd6554;
  localparam logic [15:0] ALPHA_DECAY_RST = 16'd16220;
  localparam logic [7:0]  MIN_POS_RST     = 8'd5;
  localparam logic        MIX_MODE_RST    = 1'b0;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    REG_DT_START    = 3'd0,
    REG_DT_MAX      = 3'd1,
    REG_GROW        = 3'd2,
    REG_SHRINK      = 3'd3,
    REG_ALPHA_START = 3'd4,
    REG_ALPHA_DECAY = 3'd5,
    REG_MIN_POS     = 3'd6,
    REG_MIX_MODE    = 3'd7
  } cfg_reg_t;

  typedef enum logic [20:0] {
    S_IDLE   = 21'd1 << 0,
    S_ACC1   = 21'd1 << 1,
    S_ACC2   = 21'd1 << 2,
    S_ACC3   = 21'd1 << 3,
    S_RULE   = 21'd1 << 4,
    S_GROOT  = 21'd1 << 5,
    S_NREAD  = 21'd1 << 6,
    S_NLOAD  = 21'd1 << 7,
    S_NSQ    = 21'd1 << 8,
    S_NSQSUM = 21'd1 << 9,
    S_NSQCHK = 21'd1 << 10,
    S_NROOT  = 21'd1 << 11,
    S_MIXA   = 21'd1 << 12,
    S_MIXB   = 21'd1 << 13,
    S_MIXC   = 21'd1 << 14,
    S_INT1   = 21'd1 << 15,
    S_INT2   = 21'd1 << 16,
    S_INT3   = 21'd1 << 17,
    S_INT4   = 21'd1 << 18,
    S_NWRITE = 21'd1 << 19,
    S_FIN    = 21'd1 << 20
  } ctrl_state_t;

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_DIV  = 4'b0010,
    R_SQRT = 4'b0100,
    R_DONE = 4'b1000
  } root_state_t;

  typedef struct packed {
    logic load_wr;
    logic step_wr;
    logic restart;
    logic clr_sums;
    logic acc_mul;
    logic acc_add1;
    logic acc_add2;
    logic rule;
    logic g_start;
    logic g_take;
    logic use_k;
    logic node_cap;
    logic sq_mul;
    logic sq_add;
    logic ratio_clr;
    logic n_start;
    logic n_take;
    logic mix_a;
    logic mix_b;
    logic mix_c;
    logic int1;
    logic int2;
    logic int3;
    logic int4;
    logic node_write;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic pos_now;
    logic pos;
    logic fsq_zero;
    logic mode;
    logic fs_zero;
    logic root_done;
    logic k_last;
  } dp_status_t;

endpackage

`default_nettype wire

[hw/rtl/frs_root.sv]
// ----------------------------------------------------------------------------
// frs_root
// Iterative sqrt(num/den) in Q16.16: one quotient bit per cycle, then one
// root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_root (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  output logic             done,
  output logic [31:0]      root
);

  frs_pkg::root_state_t rs_r;
  logic [63:0] den_r;
  logic [63:0] rem_r;
  logic [63:0] sh_r;
  logic [33:0] sqrem_r;
  logic [31:0] root_r;
  logic [5:0]  cnt_r;

  logic [64:0] r2;
  logic [64:0] rsub;
  logic        ge;
  logic [35:0] rem4;
  logic [35:0] trial;
  logic [35:0] sdiff;
  logic        sge;

  always_comb begin
    r2    = {rem_r, sh_r[63]};
    ge    = r2 >= {1'b0, den_r};
    rsub  = r2 - {1'b0, den_r};
    rem4  = {sqrem_r, sh_r[63:62]};
    trial = {2'b00, root_r, 2'b01};
    sge   = rem4 >= trial;
    sdiff = rem4 - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_r <= frs_pkg::R_IDLE;
    end else begin
      unique case (rs_r)
        frs_pkg::R_IDLE: begin
          if (start) begin
            den_r <= den;
            rem_r <= {32'd0, num[63:32]};
            sh_r  <= {num[31:0], 32'd0};
            cnt_r <= '0;
            if (num[63:32] >= den) begin
              root_r <= '1;
              rs_r   <= frs_pkg::R_DONE;
            end else begin
              rs_r <= frs_pkg::R_DIV;
            end
          end
        end
        frs_pkg::R_DIV: begin
          rem_r <= ge ? rsub[63:0] : r2[63:0];
          sh_r  <= {sh_r[62:0], ge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            sqrem_r <= '0;
            root_r  <= '0;
            rs_r    <= frs_pkg::R_SQRT;
          end
        end
        frs_pkg::R_SQRT: begin
          sqrem_r <= sge ? sdiff[33:0] : rem4[33:0];
          root_r  <= {root_r[30:0], sge};
          sh_r    <= {sh_r[61:0], 2'b00};
          cnt_r   <= cnt_r + 6'd1;
          if (cnt_r[4:0] == 5'd31) begin
            rs_r <= frs_pkg::R_DONE;
          end
        end
        frs_pkg::R_DONE: begin
          rs_r <= frs_pkg::R_IDLE;
        end
        default: begin
          rs_r <= frs_pkg::R_IDLE;
        end
      endcase
    end
  end

  assign done = (rs_r == frs_pkg::R_DONE);
  assign root = root_r;

endmodule

`default_nettype wire

[hw/rtl/frs_datapath.sv]
// ----------------------------------------------------------------------------
// frs_datapath
// Node stores, configuration, accumulators, FIRE rule and per-node update
// arithmetic, driven step by step by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire frs_pkg::dp_cmd_t              cmd,
  output frs_pkg::dp_status_t                status,
  input  wire logic signed [31:0]            in_value_x,
  input  wire logic signed [31:0]            in_value_y,
  input  wire logic                          cfg_we,
  input  wire logic [frs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [frs_pkg::CFG_W-1:0]     cfg_wdata,
  output logic [frs_pkg::IDX_W-1:0]          out_node_index,
  output logic signed [31:0]                 out_new_pos_x,
  output logic signed [31:0]                 out_new_pos_y,
  output logic                               out_power_positive,
  output logic                               out_last_result
);

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v[63:31] != {33{v[63]}}) begin
      return v[63] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s;
  endfunction

  function automatic logic [63:0] uadd64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  // configuration
  logic [23:0] dt_start_r, dt_max_r;
  logic [15:0] grow_r, shrink_r, alpha_start_r, alpha_decay_r;
  logic [7:0]  min_pos_r;
  logic        mode_r;

  // relaxation state
  logic [23:0]               ts_r;
  logic [15:0]               alpha_r;
  logic [7:0]                pc_r;
  logic [frs_pkg::CNT_W-1:0] cnt_r;
  logic [frs_pkg::CNT_W-1:0] k_r;
  logic signed [63:0]        power_r;
  logic [63:0]               fsq_r, vsq_r;
  logic                      positive_r;
  logic [31:0]               gratio_r, ratio_r;

  // stores
  logic signed [31:0] pos_x_mem [frs_pkg::NODES];
  logic signed [31:0] pos_y_mem [frs_pkg::NODES];
  logic signed [31:0] vel_x_mem [frs_pkg::NODES];
  logic signed [31:0] vel_y_mem [frs_pkg::NODES];
  logic signed [31:0] frc_x_mem [frs_pkg::NODES];
  logic signed [31:0] frc_y_mem [frs_pkg::NODES];
  logic [frs_pkg::NODES-1:0] vel_vld_r;
  logic signed [31:0] pos_x_rd, pos_y_rd, vel_x_rd, vel_y_rd, frc_x_rd, frc_y_rd;
  logic               vld_rd_r;

  // working registers
  logic signed [31:0] inx_r, iny_r;
  logic signed [63:0] pax_r, pay_r;
  logic [63:0]        ax2_r, ay2_r, bx2_r, by2_r;
  logic [63:0]        fsq_t_r, vsq_t_r;
  logic signed [31:0] fx_r, fy_r, ux_r, uy_r, px_r, py_r;
  logic [31:0]        sc_r;
  logic signed [33:0] ax_r, ay_r;
  logic signed [48:0] bx_r, by_r;
  logic signed [40:0] pvx_r, pvy_r, ppx_r, ppy_r;

  logic [frs_pkg::ADDR_W-1:0] addr;
  logic signed [31:0] velx, vely;
  logic signed [31:0] max_, may_, mbx, mby;
  logic               pos_now;
  logic [15:0]        fac;
  logic [39:0]        tprod;
  logic [23:0]        tsat;
  logic [31:0]        aprod;
  logic [15:0]        asat;
  logic [7:0]         pc_inc;
  logic [16:0]        oma;
  logic signed [17:0] oma_s;
  logic signed [24:0] dts;
  logic signed [49:0] amx, amy;
  logic [47:0]        scp;
  logic signed [64:0] bmx, bmy;
  logic signed [56:0] fvx, fvy, upx, upy;
  logic               root_start, root_done;
  logic [31:0]        root_res;
  logic               pos_we;
  logic signed [31:0] pos_wx, pos_wy;

  assign addr = cmd.use_k ? k_r[frs_pkg::ADDR_W-1:0] : cnt_r[frs_pkg::ADDR_W-1:0];
  assign velx = vld_rd_r ? vel_x_rd : 32'sd0;
  assign vely = vld_rd_r ? vel_y_rd : 32'sd0;

  always_comb begin
    max_    = cmd.acc_mul ? inx_r : fx_r;
    may_    = cmd.acc_mul ? iny_r : fy_r;
    mbx     = cmd.acc_mul ? velx : ux_r;
    mby     = cmd.acc_mul ? vely : uy_r;
    pos_now = !power_r[63] && (power_r != 64'sd0);
    fac     = pos_now ? grow_r : shrink_r;
    tprod   = ts_r * fac;
    tsat    = (tprod[39:38] != 2'b00) ? 24'hFFFFFF : tprod[37:14];
    aprod   = alpha_r * alpha_decay_r;
    asat    = (aprod[31:30] != 2'b00) ? 16'hFFFF : aprod[29:14];
    pc_inc  = (pc_r == 8'hFF) ? pc_r : pc_r + 8'd1;
    oma     = 17'h10000 - {1'b0, alpha_r};
    oma_s   = signed'({1'b0, oma});
    dts     = signed'({1'b0, ts_r});
    amx     = oma_s * ux_r;
    amy     = oma_s * uy_r;
    scp     = alpha_r * ratio_r;
    bmx     = signed'({1'b0, sc_r}) * fx_r;
    bmy     = signed'({1'b0, sc_r}) * fy_r;
    fvx     = fx_r * dts;
    fvy     = fy_r * dts;
    upx     = ux_r * dts;
    upy     = uy_r * dts;
    pos_we  = cmd.load_wr || cmd.node_write;
    pos_wx  = cmd.load_wr ? in_value_x : px_r;
    pos_wy  = cmd.load_wr ? in_value_y : py_r;
  end

  assign root_start = cmd.g_start || cmd.n_start;

  frs_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .num   (cmd.n_start ? vsq_t_r : vsq_r),
    .den   (cmd.n_start ? fsq_t_r : fsq_r),
    .done  (root_done),
    .root  (root_res)
  );

  // node stores
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_x_mem[addr] <= pos_wx;
      pos_y_mem[addr] <= pos_wy;
    end
    if (cmd.node_write) begin
      vel_x_mem[addr] <= ux_r;
      vel_y_mem[addr] <= uy_r;
    end
    if (cmd.step_wr) begin
      frc_x_mem[addr] <= in_value_x;
      frc_y_mem[addr] <= in_value_y;
    end
    pos_x_rd <= pos_x_mem[addr];
    pos_y_rd <= pos_y_mem[addr];
    vel_x_rd <= vel_x_mem[addr];
    vel_y_rd <= vel_y_mem[addr];
    frc_x_rd <= frc_x_mem[addr];
    frc_y_rd <= frc_y_mem[addr];
    vld_rd_r <= vel_vld_r[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_vld_r <= '0;
    end else if (cmd.load_wr) begin
      vel_vld_r[addr] <= 1'b0;
    end else if (cmd.node_write) begin
      vel_vld_r[addr] <= 1'b1;
    end
  end

  // configuration and relaxation control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_start_r    <= frs_pkg::DT_START_RST;
      dt_max_r      <= frs_pkg::DT_MAX_RST;
      grow_r        <= frs_pkg::GROW_RST;
      shrink_r      <= frs_pkg::SHRINK_RST;
      alpha_start_r <= frs_pkg::ALPHA_START_RST;
      alpha_decay_r <= frs_pkg::ALPHA_DECAY_RST;
      min_pos_r     <= frs_pkg::MIN_POS_RST;
      mode_r        <= frs_pkg::MIX_MODE_RST;
      ts_r          <= frs_pkg::DT_START_RST;
      alpha_r       <= frs_pkg::ALPHA_START_RST;
      pc_r          <= '0;
      cnt_r         <= '0;
      power_r       <= '0;
      fsq_r         <= '0;
      vsq_r         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (frs_pkg::cfg_reg_t'(cfg_index))
          frs_pkg::REG_DT_START:    dt_start_r    <= cfg_wdata[23:0];
          frs_pkg::REG_DT_MAX:      dt_max_r      <= cfg_wdata[23:0];
          frs_pkg::REG_GROW:        grow_r        <= cfg_wdata[15:0];
          frs_pkg::REG_SHRINK:      shrink_r      <= cfg_wdata[15:0];
          frs_pkg::REG_ALPHA_START: alpha_start_r <= cfg_wdata[15:0];
          frs_pkg::REG_ALPHA_DECAY: alpha_decay_r <= cfg_wdata[15:0];
          frs_pkg::REG_MIN_POS:     min_pos_r     <= cfg_wdata[7:0];
          frs_pkg::REG_MIX_MODE:    mode_r        <= cfg_wdata[0];
        endcase
      end
      if (cmd.restart) begin
        ts_r    <= dt_start_r;
        alpha_r <= alpha_start_r;
        pc_r    <= '0;
      end else if (cmd.rule) begin
        if (!pos_now) begin
          ts_r    <= tsat;
          alpha_r <= alpha_start_r;
          pc_r    <= '0;
        end else begin
          pc_r <= pc_inc;
          if (pc_inc > min_pos_r) begin
            ts_r    <= (tsat > dt_max_r) ? dt_max_r : tsat;
            alpha_r <= asat;
          end
        end
      end
      if (cmd.clr_sums) begin
        cnt_r <= '0;
      end else if (cmd.load_wr || cmd.acc_add2) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.clr_sums) begin
        power_r <= '0;
        fsq_r   <= '0;
        vsq_r   <= '0;
      end else if (cmd.acc_add1) begin
        power_r <= sadd64(power_r, pax_r);
      end else if (cmd.acc_add2) begin
        power_r <= sadd64(power_r, pay_r);
        fsq_r   <= uadd64(fsq_r, fsq_t_r);
        vsq_r   <= uadd64(vsq_r, vsq_t_r);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.step_wr) begin
      inx_r <= in_value_x;
      iny_r <= in_value_y;
    end
    if (cmd.acc_mul || cmd.sq_mul) begin
      pax_r <= max_ * mbx;
      pay_r <= may_ * mby;
      ax2_r <= max_ * max_;
      ay2_r <= may_ * may_;
      bx2_r <= mbx * mbx;
      by2_r <= mby * mby;
    end
    if (cmd.acc_add1 || cmd.sq_add) begin
      fsq_t_r <= ax2_r + ay2_r;
      vsq_t_r <= bx2_r + by2_r;
    end
    if (cmd.rule) begin
      positive_r <= pos_now;
      k_r        <= '0;
      gratio_r   <= '0;
    end else if (cmd.node_write) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.g_take) begin
      gratio_r <= root_res;
    end
    if (cmd.node_cap) begin
      fx_r    <= frc_x_rd;
      fy_r    <= frc_y_rd;
      ux_r    <= positive_r ? velx : 32'sd0;
      uy_r    <= positive_r ? vely : 32'sd0;
      px_r    <= pos_x_rd;
      py_r    <= pos_y_rd;
      ratio_r <= gratio_r;
    end
    if (cmd.ratio_clr) begin
      ratio_r <= '0;
    end else if (cmd.n_take) begin
      ratio_r <= root_res;
    end
    if (cmd.mix_a) begin
      sc_r <= scp[47:16];
      ax_r <= amx[49:16];
      ay_r <= amy[49:16];
    end
    if (cmd.mix_b) begin
      bx_r <= bmx[64:16];
      by_r <= bmy[64:16];
    end
    if (cmd.mix_c) begin
      ux_r <= sat32(64'(ax_r) + 64'(bx_r));
      uy_r <= sat32(64'(ay_r) + 64'(by_r));
    end
    if (cmd.int1) begin
      pvx_r <= fvx[56:16];
      pvy_r <= fvy[56:16];
      ppx_r <= upx[56:16];
      ppy_r <= upy[56:16];
    end
    if (cmd.int2) begin
      ux_r <= sat32(64'(ux_r) + 64'(pvx_r));
      uy_r <= sat32(64'(uy_r) + 64'(pvy_r));
      if (mode_r) begin
        px_r <= sat32(64'(px_r) + 64'(ppx_r));
        py_r <= sat32(64'(py_r) + 64'(ppy_r));
      end
    end
    if (cmd.int3) begin
      ppx_r <= upx[56:16];
      ppy_r <= upy[56:16];
    end
    if (cmd.int4) begin
      px_r <= sat32(64'(px_r) + 64'(ppx_r));
      py_r <= sat32(64'(py_r) + 64'(ppy_r));
    end
  end

  always_comb begin
    status.full      = cnt_r >= frs_pkg::CNT_W'(frs_pkg::NODES);
    status.cnt_zero  = cnt_r == '0;
    status.pos_now   = pos_now;
    status.pos       = positive_r;
    status.fsq_zero  = fsq_r == 64'd0;
    status.mode      = mode_r;
    status.fs_zero   = fsq_t_r == 64'd0;
    status.root_done = root_done;
    status.k_last    = frs_pkg::CNT_W'(k_r + 1'b1) == cnt_r;
  end

  assign out_node_index     = frs_pkg::IDX_W'(k_r);
  assign out_new_pos_x      = px_r;
  assign out_new_pos_y      = py_r;
  assign out_power_positive = positive_r;
  assign out_last_result    = status.k_last;

endmodule

`default_nettype wire

[hw/rtl/frs_ctrl.sv]
// ----------------------------------------------------------------------------
// frs_ctrl
// Sequencer for request intake, accumulation, the FIRE rule and the
// node-by-node update pass.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [1:0]          in_command,
  input  wire logic                in_last_node,
  input  wire frs_pkg::dp_status_t status,
  output frs_pkg::dp_cmd_t         cmd,
  output logic                     busy,
  output logic                     out_valid
);

  frs_pkg::ctrl_state_t state_r, state_nxt;
  logic                 last_r, last_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    last_nxt  = last_r;
    unique case (state_r)
      frs_pkg::S_IDLE: begin
        if (start) begin
          last_nxt = in_last_node;
          unique case (frs_pkg::cmd_code_t'(in_command))
            frs_pkg::CMD_LOAD: begin
              cmd.load_wr  = !status.full;
              cmd.clr_sums = in_last_node;
            end
            frs_pkg::CMD_STEP: begin
              if (!status.full) begin
                cmd.step_wr = 1'b1;
                state_nxt   = frs_pkg::S_ACC1;
              end else if (in_last_node) begin
                state_nxt = frs_pkg::S_RULE;
              end
            end
            frs_pkg::CMD_RESTART: cmd.restart = 1'b1;
            frs_pkg::CMD_UNUSED: ;
          endcase
        end
      end
      frs_pkg::S_ACC1: begin
        cmd.acc_mul = 1'b1;
        state_nxt   = frs_pkg::S_ACC2;
      end
      frs_pkg::S_ACC2: begin
        cmd.acc_add1 = 1'b1;
        state_nxt    = frs_pkg::S_ACC3;
      end
      frs_pkg::S_ACC3: begin
        cmd.acc_add2 = 1'b1;
        state_nxt    = last_r ? frs_pkg::S_RULE : frs_pkg::S_IDLE;
      end
      frs_pkg::S_RULE: begin
        cmd.rule = 1'b1;
        if (status.pos_now && !status.fsq_zero && !status.mode) begin
          cmd.g_start = 1'b1;
          state_nxt   = frs_pkg::S_GROOT;
        end else begin
          state_nxt = status.cnt_zero ? frs_pkg::S_FIN : frs_pkg::S_NREAD;
        end
      end
      frs_pkg::S_GROOT: begin
        if (status.root_done) begin
          cmd.g_take = 1'b1;
          state_nxt  = status.cnt_zero ? frs_pkg::S_FIN : frs_pkg::S_NREAD;
        end
      end
      frs_pkg::S_NREAD: begin
        cmd.use_k = 1'b1;
        state_nxt = frs_pkg::S_NLOAD;
      end
      frs_pkg::S_NLOAD: begin
        cmd.node_cap = 1'b1;
        priority if (!status.pos) begin
          state_nxt = frs_pkg::S_INT1;
        end else if (status.mode) begin
          state_nxt = frs_pkg::S_NSQ;
        end else begin
          state_nxt = frs_pkg::S_MIXA;
        end
      end
      frs_pkg::S_NSQ: begin
        cmd.sq_mul = 1'b1;
        state_nxt  = frs_pkg::S_NSQSUM;
      end
      frs_pkg::S_NSQSUM: begin
        cmd.sq_add = 1'b1;
        state_nxt  = frs_pkg::S_NSQCHK;
      end
      frs_pkg::S_NSQCHK: begin
        if (status.fs_zero) begin
          cmd.ratio_clr = 1'b1;
          state_nxt     = frs_pkg::S_MIXA;
        end else begin
          cmd.n_start = 1'b1;
          state_nxt   = frs_pkg::S_NROOT;
        end
      end
      frs_pkg::S_NROOT: begin
        if (status.root_done) begin
          cmd.n_take = 1'b1;
          state_nxt  = frs_pkg::S_MIXA;
        end
      end
      frs_pkg::S_MIXA: begin
        cmd.mix_a = 1'b1;
        state_nxt = frs_pkg::S_MIXB;
      end
      frs_pkg::S_MIXB: begin
        cmd.mix_b = 1'b1;
        state_nxt = frs_pkg::S_MIXC;
      end
      frs_pkg::S_MIXC: begin
        cmd.mix_c = 1'b1;
        state_nxt = frs_pkg::S_INT1;
      end
      frs_pkg::S_INT1: begin
        cmd.int1  = 1'b1;
        state_nxt = frs_pkg::S_INT2;
      end
      frs_pkg::S_INT2: begin
        cmd.int2  = 1'b1;
        state_nxt = status.mode ? frs_pkg::S_NWRITE : frs_pkg::S_INT3;
      end
      frs_pkg::S_INT3: begin
        cmd.int3  = 1'b1;
        state_nxt = frs_pkg::S_INT4;
      end
      frs_pkg::S_INT4: begin
        cmd.int4  = 1'b1;
        state_nxt = frs_pkg::S_NWRITE;
      end
      frs_pkg::S_NWRITE: begin
        cmd.use_k      = 1'b1;
        cmd.node_write = 1'b1;
        state_nxt      = status.k_last ? frs_pkg::S_FIN : frs_pkg::S_NREAD;
      end
      frs_pkg::S_FIN: begin
        cmd.clr_sums = 1'b1;
        state_nxt    = frs_pkg::S_IDLE;
      end
      default: begin
        state_nxt = frs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frs_pkg::S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  assign busy      = (state_r != frs_pkg::S_IDLE);
  assign out_valid = (state_r == frs_pkg::S_NWRITE);

endmodule

`default_nettype wire

[hw/rtl/fire_relaxation_step_unit.sv]
// ----------------------------------------------------------------------------
// fire_relaxation_step_unit
// FIRE relaxation step over up to 64 nodes in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Load and restart
// requests are handled without leaving idle; a step force request passes one
// multiply and two saturating add stages. The step request marked last_node
// then runs the rule and an update pass of one node at a time, emitting each
// new position with out_valid high for a single cycle; the receiver cannot
// hold results off, so out_valid must be taken when it appears. Per node the
// pass reads the node and, in global mode with positive power, mixes velocity
// and force before integrating; without positive power the mix is skipped.
// In per-node mode with positive power it first runs the shared root unit
// (quotient, then square root, then hand-over) unless the force sum is zero.
// With positive power and a nonzero force sum in global mode the pass is
// preceded by one such root.
// ----------------------------------------------------------------------------
`default_nettype none

module fire_relaxation_step_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_command,
  input  wire logic signed [31:0]            in_value_x,
  input  wire logic signed [31:0]            in_value_y,
  input  wire logic                          in_last_node,
  output logic                               out_valid,
  output logic [frs_pkg::IDX_W-1:0]          out_node_index,
  output logic signed [31:0]                 out_new_pos_x,
  output logic signed [31:0]                 out_new_pos_y,
  output logic                               out_power_positive,
  output logic                               out_last_result,
  input  wire logic                          cfg_we,
  input  wire logic [frs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [frs_pkg::CFG_W-1:0]     cfg_wdata
);

  frs_pkg::dp_cmd_t    cmd;
  frs_pkg::dp_status_t status;

  frs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_command   (in_command),
    .in_last_node (in_last_node),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  frs_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_value_x         (in_value_x),
    .in_value_y         (in_value_y),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_node_index     (out_node_index),
    .out_new_pos_x      (out_new_pos_x),
    .out_new_pos_y      (out_new_pos_y),
    .out_power_positive (out_power_positive),
    .out_last_result    (out_last_result)
  );

endmodule

`default_nettype wire
